/* hdl/gasc_pkg.sv */
// ============================================================================
// Glyph slot cache package
// Shared types and codes for the glyph atlas slot cache.
// ============================================================================
package gasc_pkg;

    // Result status codes.
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_RESIDENT = 3'd1;
    localparam logic [2:0] ST_PLACED   = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_FREED    = 3'd4;
    localparam logic [2:0] ST_NO_SPACE = 3'd5;

    // Operation codes.
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // List marks kept with each glyph.
    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_USE  = 2'd1;
    localparam logic [1:0] MARK_FREE = 2'd2;

    localparam logic [15:0] REF_MAX = 16'hFFFF;

    // Configuration register indexes (address bit 2).
    localparam logic REG_GLYPH_COUNT   = 1'b0;
    localparam logic REG_SLOTS_PER_ROW = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic start;
        logic eval;
        logic evict_rd;
        logic evict_fin;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic evict;
    } t_dp_stat;

endpackage

/* hdl/gasc_req_if.sv */
// ============================================================================
// Request channel
// Valid/ready channel carrying one acquire or release request.
// ============================================================================
interface gasc_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [9:0] glyph_index;

    modport source (output valid, output operation, output glyph_index, input ready);
    modport sink   (input valid, input operation, input glyph_index, output ready);
endinterface

/* hdl/gasc_rsp_if.sv */
// ============================================================================
// Result channel
// Valid/ready channel carrying one result of the slot cache.
// ============================================================================
interface gasc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] page;
    logic [5:0] slot_col;
    logic [5:0] slot_row;
    logic       evicted_valid;
    logic [9:0] evicted_glyph;

    modport source (output valid, output status, output page, output slot_col,
                    output slot_row, output evicted_valid, output evicted_glyph,
                    input ready);
    modport sink   (input valid, input status, input page, input slot_col,
                    input slot_row, input evicted_valid, input evicted_glyph,
                    output ready);
endinterface

/* hdl/gasc_ctrl.sv */
// ============================================================================
// Slot cache controller
// Sequences the clearing pass and the memory steps of each request.
// ============================================================================
module gasc_ctrl
    import gasc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_clr_busy
);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD1  = 6'b000100,
        S_RD2  = 6'b001000,
        S_WR   = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_clr_busy  = (r_state == S_CLR);

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_stat.in_range ? S_RD1 : S_DONE;
                end
            end
            S_RD1: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.evict ? S_RD2 : S_DONE;
            end
            S_RD2: begin
                o_cmd.evict_rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.evict_fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/gasc_dp.sv */
// ============================================================================
// Slot cache datapath
// Glyph memories, free list pointers, page fill state and the result register.
// ============================================================================
module gasc_dp
    import gasc_pkg::*;
#(
    parameter int GLYPHS            = 1024,
    parameter int MAX_PAGES         = 16,
    parameter int MAX_SLOTS_PER_ROW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [10:0] i_glyph_count,
    input  logic [6:0]  i_slots_per_row,
    input  logic        i_operation,
    input  logic [9:0]  i_glyph_index,
    output logic [2:0]  o_status,
    output logic [3:0]  o_page,
    output logic [5:0]  o_slot_col,
    output logic [5:0]  o_slot_row,
    output logic        o_evicted_valid,
    output logic [9:0]  o_evicted_glyph
);

    localparam int GW = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
    localparam int CW = $clog2(GLYPHS + 1);
    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam int SW = $clog2(MAX_SLOTS_PER_ROW + 1);

    // Memories: {mark, count}, {page, column, row}, list links.
    logic [17:0]   st_mem [GLYPHS];
    logic [15:0]   sl_mem [GLYPHS];
    logic [GW-1:0] nx_mem [GLYPHS];
    logic [GW-1:0] pv_mem [GLYPHS];

    logic [17:0]   st_rd;
    logic [15:0]   sl_rd;
    logic [GW-1:0] nx_rd, pv_rd;

    logic          st_we, sl_we, nx_we, pv_we;
    logic [GW-1:0] st_wa, sl_wa, nx_wa, pv_wa, rd_a;
    logic [17:0]   st_wd;
    logic [15:0]   sl_wd;
    logic [GW-1:0] nx_wd, pv_wd;

    // Control and list registers.
    logic [GW-1:0] r_clr, r_g, r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_pages, n_pages;
    logic [SW-1:0] r_fcol, n_fcol, r_fline, n_fline;
    logic          r_op;
    logic          evict;

    // Pending result and output registers.
    logic [2:0]  r_res_st, n_res_st;
    logic [15:0] r_res_sl, n_res_sl;
    logic        r_res_ev, n_res_ev;
    logic [9:0]  r_res_eg, n_res_eg;
    logic [2:0]  r_o_st;
    logic [15:0] r_o_sl;
    logic        r_o_ev;
    logic [9:0]  r_o_eg;

    // Input index mapped onto the memory address width and back.
    logic [GW+9:0] g_wide;
    logic [GW-1:0] g_addr;
    logic [GW+9:0] h_wide;
    assign g_wide = {{GW{1'b0}}, i_glyph_index};
    assign g_addr = g_wide[GW-1:0];
    assign h_wide = {10'b0, r_head};

    assign o_stat.in_range = ({1'b0, i_glyph_index} < i_glyph_count)
                          && (32'(i_glyph_index) < GLYPHS);
    assign o_stat.clr_last = (32'(r_clr) == GLYPHS - 1);
    assign o_stat.evict    = evict;

    // Effective slots per row.
    logic [SW-1:0] spr;
    always_comb begin
        if (i_slots_per_row == 7'd0)             spr = SW'(1);
        else if (32'(i_slots_per_row) > MAX_SLOTS_PER_ROW) spr = SW'(MAX_SLOTS_PER_ROW);
        else                                     spr = SW'(i_slots_per_row);
    end

    function automatic logic fr_ge(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return a >= b;
    endfunction

    // Fresh slot arithmetic.
    logic          need_page, no_room;
    logic [PW-1:0] pg_new;
    logic [PW+3:0] pg_idx;
    logic [SW-1:0] fc, fl;
    logic [SW:0]   fc_inc;
    logic [SW+5:0] fc_w, fl_w;
    assign need_page = (r_pages == '0) || (fr_ge(r_fline, spr));
    assign no_room   = need_page && (32'(r_pages) >= MAX_PAGES);
    assign pg_new    = need_page ? r_pages + PW'(1) : r_pages;
    assign pg_idx    = {4'b0, pg_new - PW'(1)};
    assign fc        = need_page ? '0 : r_fcol;
    assign fl        = need_page ? '0 : r_fline;
    assign fc_inc    = {1'b0, fc} + (SW+1)'(1);
    assign fc_w      = {6'b0, fc};
    assign fl_w      = {6'b0, fl};

    logic [15:0] rc;
    logic [1:0]  mark;
    logic [15:0] rc_dn;
    assign rc    = st_rd[15:0];
    assign mark  = st_rd[17:16];
    assign rc_dn = rc - 16'd1;

    // Datapath next values and memory writes.
    always_comb begin
        st_we = 1'b0; st_wa = r_g; st_wd = '0;
        sl_we = 1'b0; sl_wa = r_g; sl_wd = '0;
        nx_we = 1'b0; nx_wa = '0;  nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0;  pv_wd = '0;
        n_head = r_head; n_tail = r_tail; n_count = r_count;
        n_pages = r_pages; n_fcol = r_fcol; n_fline = r_fline;
        n_res_st = r_res_st; n_res_sl = r_res_sl;
        n_res_ev = r_res_ev; n_res_eg = r_res_eg;
        evict = 1'b0;
        rd_a = i_cmd.start ? g_addr : r_head;

        if (i_cmd.clr_step) begin
            st_we = 1'b1;
            st_wa = r_clr;
        end

        if (i_cmd.start) begin
            n_res_st = ST_IGNORED;
            n_res_sl = '0;
            n_res_ev = 1'b0;
            n_res_eg = '0;
        end

        if (i_cmd.eval) begin
            if (r_op == OP_ACQUIRE) begin
                if (rc != 16'd0) begin
                    // Already referenced: count up, saturating.
                    st_we = 1'b1;
                    st_wd = {mark, (rc == REF_MAX) ? rc : rc + 16'd1};
                    n_res_st = ST_RESIDENT;
                    n_res_sl = sl_rd;
                end else if (mark == MARK_FREE) begin
                    // Waiting on the free list: unlink it and keep its slot.
                    if (r_count <= CW'(1)) begin
                        n_head = '0; n_tail = '0; n_count = '0;
                    end else begin
                        if (r_g == r_head) n_head = nx_rd;
                        else begin
                            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                        end
                        if (r_g == r_tail) n_tail = pv_rd;
                        else begin
                            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                        end
                        n_count = r_count - CW'(1);
                    end
                    st_we = 1'b1;
                    st_wd = {MARK_USE, 16'd1};
                    n_res_st = ST_RESIDENT;
                    n_res_sl = sl_rd;
                end else if (r_count != '0) begin
                    // Take the oldest freed slot over the next two steps.
                    evict = 1'b1;
                end else if (!no_room) begin
                    // Fresh slot, opening a page when needed.
                    sl_we = 1'b1;
                    sl_wd = {pg_idx[3:0], fc_w[5:0], fl_w[5:0]};
                    n_pages = pg_new;
                    if (fc_inc >= {1'b0, spr}) begin
                        n_fcol  = '0;
                        n_fline = fl + SW'(1);
                    end else begin
                        n_fcol  = fc_inc[SW-1:0];
                        n_fline = fl;
                    end
                    st_we = 1'b1;
                    st_wd = {MARK_USE, 16'd1};
                    n_res_st = ST_PLACED;
                    n_res_sl = sl_wd;
                end else begin
                    n_res_st = ST_NO_SPACE;
                end
            end else if (rc != 16'd0) begin
                st_we = 1'b1;
                n_res_sl = sl_rd;
                if (rc_dn == 16'd0) begin
                    // Last reference gone: append to the free list tail.
                    if (r_count == '0) begin
                        n_head = r_g;
                    end else begin
                        nx_we = 1'b1; nx_wa = r_tail; nx_wd = r_g;
                        pv_we = 1'b1; pv_wa = r_g;    pv_wd = r_tail;
                    end
                    n_tail  = r_g;
                    n_count = r_count + CW'(1);
                    st_wd = {MARK_FREE, 16'd0};
                    n_res_st = ST_FREED;
                end else begin
                    st_wd = {mark, rc_dn};
                    n_res_st = ST_RELEASED;
                end
            end
        end

        if (i_cmd.evict_rd) begin
            // Head entry read back: move its slot and drop it from the list.
            sl_we = 1'b1; sl_wd = sl_rd;
            st_we = 1'b1; st_wa = r_head; st_wd = {MARK_NONE, 16'd0};
            if (r_count <= CW'(1)) begin
                n_head = '0; n_tail = '0; n_count = '0;
            end else begin
                n_head  = nx_rd;
                n_count = r_count - CW'(1);
            end
            n_res_st = ST_PLACED;
            n_res_sl = sl_rd;
            n_res_ev = 1'b1;
            n_res_eg = h_wide[9:0];
        end

        if (i_cmd.evict_fin) begin
            st_we = 1'b1;
            st_wd = {MARK_USE, 16'd1};
        end
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        if (sl_we) sl_mem[sl_wa] <= sl_wd;
        if (nx_we) nx_mem[nx_wa] <= nx_wd;
        if (pv_we) pv_mem[pv_wa] <= pv_wd;
        st_rd <= st_mem[rd_a];
        sl_rd <= sl_mem[rd_a];
        nx_rd <= nx_mem[rd_a];
        pv_rd <= pv_mem[rd_a];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pages <= '0;
            r_fcol  <= '0;
            r_fline <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + GW'(1);
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pages <= n_pages;
            r_fcol  <= n_fcol;
            r_fline <= n_fline;
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_operation;
            r_g  <= g_addr;
        end
        r_res_st <= n_res_st;
        r_res_sl <= n_res_sl;
        r_res_ev <= n_res_ev;
        r_res_eg <= n_res_eg;
        if (i_cmd.load_out) begin
            r_o_st <= r_res_st;
            r_o_sl <= r_res_sl;
            r_o_ev <= r_res_ev;
            r_o_eg <= r_res_eg;
        end
    end

    assign o_status        = r_o_st;
    assign o_page          = r_o_sl[15:12];
    assign o_slot_col      = r_o_sl[11:6];
    assign o_slot_row      = r_o_sl[5:0];
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_glyph = r_o_eg;

endmodule

/* hdl/glyph_atlas_slot_cache.sv */
// ============================================================================
// Glyph atlas slot cache
// Reference-counted glyph slot cache with a free list and atlas page filling.
// ============================================================================
// After reset the block runs a clearing pass over every entry of its glyph
// memory and takes no request until it ends; configuration writes are taken
// throughout. Each request then takes one result: a request that is ignored
// goes from acceptance straight to the result state S_DONE, most requests
// pass the read state S_RD1 first, and an acquire that evicts the oldest
// freed glyph also passes S_RD2 and S_WR, since it reads that glyph's slot
// and link from the same memories after the requester's entry and writes
// both entries' marks through one port. One request is in work at a time;
// a finished result waits in the output register while the next request is
// accepted, in the cycle after the result was loaded.
module glyph_atlas_slot_cache
    import gasc_pkg::*;
#(
    parameter int GLYPHS            = 1024,
    parameter int MAX_PAGES         = 16,
    parameter int MAX_SLOTS_PER_ROW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gasc_req_if.sink    i_req,
    gasc_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] r_glyph_count;
    logic [6:0]  r_slots_per_row;
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic        clr_busy;

    // Configuration registers, selected by address bit 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_count   <= 11'd0;
            r_slots_per_row <= 7'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_GLYPH_COUNT) r_glyph_count   <= pwdata[10:0];
            else                             r_slots_per_row <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GLYPH_COUNT) ? {21'b0, r_glyph_count}
                                                  : {25'b0, r_slots_per_row};

    gasc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_clr_busy  (clr_busy)
    );

    gasc_dp #(
        .GLYPHS            (GLYPHS),
        .MAX_PAGES         (MAX_PAGES),
        .MAX_SLOTS_PER_ROW (MAX_SLOTS_PER_ROW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_glyph_count   (r_glyph_count),
        .i_slots_per_row (r_slots_per_row),
        .i_operation     (i_req.operation),
        .i_glyph_index   (i_req.glyph_index),
        .o_status        (o_rsp.status),
        .o_page          (o_rsp.page),
        .o_slot_col      (o_rsp.slot_col),
        .o_slot_row      (o_rsp.slot_row),
        .o_evicted_valid (o_rsp.evicted_valid),
        .o_evicted_glyph (o_rsp.evicted_glyph)
    );

    // No request is taken while the glyph memory is being cleared.
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !i_req.ready)
        else $error("request ready during clearing pass");

    // An eviction is reported only with a placement.
    a_evict_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.evicted_valid) |-> (o_rsp.status == ST_PLACED))
        else $error("eviction reported without placement");

    // Ignored and no-space results carry no slot.
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_IGNORED || o_rsp.status == ST_NO_SPACE))
        |-> (o_rsp.page == 4'd0 && o_rsp.slot_col == 6'd0 && o_rsp.slot_row == 6'd0))
        else $error("slot shown on empty result");

endmodule
